@@ hw/rtl/vrss_pkg.sv @@
// Shared types, constants and helpers of the vertex repel/spring core.
package vrss_pkg;

    // request kinds
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_HIT   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOLOAD = 2'd2;

    // configuration register indexes
    localparam logic CFG_BOUND_X = 1'b0;
    localparam logic CFG_BOUND_Y = 1'b1;

    localparam int W       = 24;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam logic [15:0] DECAY_Q16 = 16'd63570;

    // one queued request between front and back
    typedef struct packed {
        t_req                  req;
        logic signed [W-1:0]   cx;
        logic signed [W-1:0]   cy;
        logic [IDX_W-1:0]      idx;
    } t_cmd;

    // saturate a wide signed value to 24 bits
    function automatic logic signed [W-1:0] sat24(input logic signed [W+1:0] v);
        logic signed [W+1:0] lo;
        logic signed [W+1:0] hi;
        lo = -(26'sd1 <<< (W-1));
        hi = (26'sd1 <<< (W-1)) - 26'sd1;
        if (v < lo) sat24 = lo[W-1:0];
        else if (v > hi) sat24 = hi[W-1:0];
        else sat24 = v[W-1:0];
    endfunction

    // absolute value, one bit wider
    function automatic logic [W:0] mag(input logic signed [W:0] v);
        mag = v[W] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ hw/rtl/vertex_repel_spring_step_core.sv @@
// Top level of the vertex repel/spring core: config, front queue, back sequencer.
//   channel | dir | handshake           | payload
//   in      | in  | i_valid / o_ready   | req_type, coord_x, coord_y, vertex_index
//   out     | out | o_valid / i_ready   | out_x, out_y, status, loaded_count
//   cfg     | in  | i_cfg_we            | i_cfg_index, i_cfg_data
// Interaction and tick walk every loaded vertex; on a tick the pull cap may run the
// square root and then two divides for a vertex.
// Reset is synchronous, active low; no clearing pass is needed.
// A waiting result blocks the sequencer; the two-word queue keeps accepting.
module vertex_repel_spring_step_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int FRAC_BITS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic signed [23:0]            i_coord_x,
    input  logic signed [23:0]            i_coord_y,
    input  logic [9:0]                    i_vertex_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [23:0]            o_out_x,
    output logic signed [23:0]            o_out_y,
    output logic [1:0]                    o_status,
    output logic [10:0]                   o_loaded_count,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [14:0]                   i_cfg_data
);
    logic [14:0] r_bound_x, r_bound_y;
    vrss_pkg::t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_x <= 15'd768; r_bound_y <= 15'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vrss_pkg::CFG_BOUND_X: r_bound_x <= i_cfg_data;
                vrss_pkg::CFG_BOUND_Y: r_bound_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_cmd.req = vrss_pkg::t_req'(i_req_type);
    assign in_cmd.cx  = i_coord_x;
    assign in_cmd.cy  = i_coord_y;
    assign in_cmd.idx = i_vertex_index;

    vrss_front #(.DEPTH(2)) u_front (.i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_cmd(in_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd));

    vrss_back #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .i_bound_x(r_bound_x), .i_bound_y(r_bound_y), .o_valid, .i_ready,
        .o_out_x, .o_out_y, .o_status, .o_loaded_count);
endmodule

@@ hw/rtl/vrss_ram.sv @@
// Generic single-port RAM with registered read.
module vrss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write through the port, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_q <= r_mem[i_addr];
    end
    assign o_rdata = r_q;
endmodule

@@ hw/rtl/vrss_front.sv @@
// Front end: accept request words and queue them for the back end.
module vrss_front #(
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  vrss_pkg::t_cmd               i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output vrss_pkg::t_cmd               o_cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    vrss_pkg::t_cmd r_q [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // hold queue entries
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overfilled");
    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("push lost");
    a_pop_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_cnt == $past(r_cnt) - 1'b1) else $error("pop lost");
endmodule

@@ hw/rtl/vrss_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module vrss_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_n,
    output logic        o_done,
    output logic [24:0] o_root
);
    logic [49:0] r_n, r_r, r_bit;
    logic        r_busy, r_done;
    logic [49:0] t;

    assign t      = r_r + r_bit;
    assign o_done = r_done;
    assign o_root = r_r[24:0];

    // one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n <= i_n; r_r <= '0; r_bit <= 50'd1 << 48; r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_n >= t) begin
                    r_n <= r_n - t;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 50'd1) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ hw/rtl/vrss_div.sv @@
// Restoring divider, one quotient bit per cycle.
module vrss_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [40:0] o_quo
);
    logic [40:0] r_q;
    logic [30:0] r_den;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [31:0] sh;

    assign sh     = {r_rem[30:0], r_q[40]};
    assign o_done = r_done;
    assign o_quo  = r_q;

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q <= i_num; r_den <= i_den; r_rem <= '0;
                r_cnt <= 6'd41; r_busy <= 1'b1;
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_q   <= {r_q[39:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q   <= {r_q[39:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ hw/rtl/vrss_back.sv @@
// Back end: sequencer that walks the vertex tables for each request.
module vrss_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int FRAC_BITS    = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  vrss_pkg::t_cmd                    i_cmd,
    input  logic [vrss_pkg::CFG_W-1:0]        i_bound_x,
    input  logic [vrss_pkg::CFG_W-1:0]        i_bound_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [vrss_pkg::W-1:0]     o_out_x,
    output logic signed [vrss_pkg::W-1:0]     o_out_y,
    output logic [1:0]                        o_status,
    output logic [vrss_pkg::CNT_W-1:0]        o_loaded_count
);
    localparam int W  = vrss_pkg::W;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [49:0] SQ_ONE = 50'd1 << (2*FRAC_BITS);
    localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_CALC, S_POS, S_SQ, S_PULL, S_ROOT,
        S_DIVX, S_DIVY, S_WB, S_OUT
    } t_state;

    t_state r_state;
    vrss_pkg::t_cmd r_cmd;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_i;
    logic [CW-1:0]  r_n;

    // memory ports
    logic we;
    logic we_home;
    logic [AW-1:0] addr;
    logic signed [W-1:0] hx_d, hy_d, cx_d, cy_d, vx_d, vy_d;
    logic signed [W-1:0] hx_q, hy_q, cx_q, cy_q, vx_q, vy_q;

    // home points change only on a load
    assign we_home = we && (r_cmd.req == vrss_pkg::REQ_LOAD);

    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_hx (.i_clk, .i_we(we_home),
        .i_addr(addr), .i_wdata(hx_d), .o_rdata(hx_q));
    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_hy (.i_clk, .i_we(we_home),
        .i_addr(addr), .i_wdata(hy_d), .o_rdata(hy_q));
    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_cx (.i_clk, .i_we(we),
        .i_addr(addr), .i_wdata(cx_d), .o_rdata(cx_q));
    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_cy (.i_clk, .i_we(we),
        .i_addr(addr), .i_wdata(cy_d), .o_rdata(cy_q));
    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_vx (.i_clk, .i_we(we),
        .i_addr(addr), .i_wdata(vx_d), .o_rdata(vx_q));
    vrss_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_vy (.i_clk, .i_we(we),
        .i_addr(addr), .i_wdata(vy_d), .o_rdata(vy_q));

    // per-vertex working registers
    logic signed [W-1:0] r_hx, r_hy, r_px, r_py, r_vx, r_vy, r_nx, r_ny;
    logic signed [W+1:0] r_gx, r_gy;
    logic [49:0]         r_s1, r_s2;
    logic [24:0]         r_q;
    logic [40:0]         r_quo_x;
    logic                r_wr;
    logic                r_sel;   // which divide is running: x (0) or y (1)
    logic signed [W-1:0] r_ox, r_oy;
    logic [1:0]          r_st;

    // helper units
    logic        sq_start, dv_start, sq_done, dv_done;
    logic [24:0] sq_root;
    logic [40:0] dv_num, dv_quo;
    logic [30:0] dv_den;
    logic [24:0] mgx, mgy;

    assign mgx = vrss_pkg::mag({r_gx[W], r_gx[W-1:0]});
    assign mgy = vrss_pkg::mag({r_gy[W], r_gy[W-1:0]});

    vrss_isqrt u_sqrt (.i_clk, .i_rst_n, .i_start(sq_start), .i_n(r_s1),
        .o_done(sq_done), .o_root(sq_root));
    vrss_div u_div (.i_clk, .i_rst_n, .i_start(dv_start), .i_num(dv_num),
        .i_den(dv_den), .o_done(dv_done), .o_quo(dv_quo));

    // root straight from the unit on the cycle the x divide starts
    logic [24:0] qq;
    logic [24:0] root_sel;
    logic        dv_second;
    assign root_sel  = (r_state == S_ROOT) ? sq_root : r_q;
    assign qq        = (root_sel == '0) ? 25'd1 : root_sel;
    assign dv_second = (r_state == S_DIVX) && dv_done && !r_sel;
    assign dv_den = 31'(qq) * 31'd40;
    assign dv_num = (41'(dv_second ? mgy : mgx) << (FRAC_BITS + 1)) + 41'(qq) * 41'd20;
    assign sq_start = (r_state == S_PULL) && (r_s1 > SQ_ONE / 50'd400);

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign addr    = (r_cmd.req == vrss_pkg::REQ_READ && r_state == S_RD)
                     ? r_cmd.idx[AW-1:0] : r_i;
    assign we      = r_wr;
    assign hx_d    = r_cmd.cx;
    assign hy_d    = r_cmd.cy;
    assign cx_d    = r_px;
    assign cy_d    = r_py;
    assign vx_d    = r_nx;
    assign vy_d    = r_ny;

    // combinational pieces on registered values
    logic signed [W:0] dx, dy;
    logic [W:0] adx, ady, avx, avy;
    logic [41:0] decx, decy;
    assign dx   = {cx_q[W-1], cx_q} - {r_cmd.cx[W-1], r_cmd.cx};
    assign dy   = {cy_q[W-1], cy_q} - {r_cmd.cy[W-1], r_cmd.cy};
    assign adx  = vrss_pkg::mag(dx);
    assign ady  = vrss_pkg::mag(dy);
    assign avx  = vrss_pkg::mag({r_vx[W-1], r_vx});
    assign avy  = vrss_pkg::mag({r_vy[W-1], r_vy});
    assign decx = (42'(avx) * 42'(vrss_pkg::DECAY_Q16) + 42'd32768) >> 16;
    assign decy = (42'(avy) * 42'(vrss_pkg::DECAY_Q16) + 42'd32768) >> 16;

    logic signed [W+1:0] gxn, gyn, sumx, sumy;
    assign dv_start = (r_state == S_ROOT && sq_done) || dv_second;
    assign sumx = {{2{r_nx[W-1]}}, r_nx} + r_gx;
    assign sumy = {{2{r_ny[W-1]}}, r_ny} + r_gy;
    assign gxn  = r_gx[W+1] ? -(W+2)'(r_quo_x) : (W+2)'(r_quo_x);
    assign gyn  = r_gy[W+1] ? -(W+2)'(dv_quo) : (W+2)'(dv_quo);

    // state, working registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_wr <= 1'b0; o_valid <= 1'b0;
        end else begin
            r_wr <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd; r_i <= '0; r_n <= '0;
                        r_ox <= '0; r_oy <= '0; r_st <= vrss_pkg::ST_OK;
                        case (i_cmd.req)
                            vrss_pkg::REQ_LOAD: begin
                                if (r_count == CW'(MAX_VERTICES)) begin
                                    r_st <= vrss_pkg::ST_FULL; r_state <= S_OUT;
                                end else begin
                                    r_i <= r_count[AW-1:0];
                                    r_px <= i_cmd.cx; r_py <= i_cmd.cy;
                                    r_nx <= '0; r_ny <= '0;
                                    r_wr <= 1'b1; r_count <= r_count + 1'b1;
                                    r_state <= S_OUT;
                                end
                            end
                            vrss_pkg::REQ_READ: begin
                                if (CW'(i_cmd.idx) >= r_count ||
                                    32'(i_cmd.idx) >= MAX_VERTICES) begin
                                    r_st <= vrss_pkg::ST_NOLOAD; r_state <= S_OUT;
                                end else r_state <= S_RD;
                            end
                            default: r_state <= (r_count == '0) ? S_OUT : S_RD;
                        endcase
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: begin
                    r_hx <= hx_q; r_hy <= hy_q; r_px <= cx_q; r_py <= cy_q;
                    r_vx <= vx_q; r_vy <= vy_q; r_nx <= vx_q; r_ny <= vy_q;
                    r_s1 <= 50'(adx) * 50'(adx);
                    r_s2 <= 50'(ady) * 50'(ady);
                    r_gx <= {dx[W], dx}; r_gy <= {dy[W], dy};
                    if (r_cmd.req == vrss_pkg::REQ_READ) begin
                        r_ox <= cx_q; r_oy <= cy_q; r_state <= S_OUT;
                    end else r_state <= S_CALC;
                end
                S_CALC: begin
                    if (r_cmd.req == vrss_pkg::REQ_HIT) begin
                        if (r_s1 + r_s2 < (SQ_ONE * 50'd100)) begin
                            r_nx <= vrss_pkg::sat24(r_gx); r_ny <= vrss_pkg::sat24(r_gy);
                        end
                        r_wr <= 1'b1; r_state <= S_WB;
                    end else begin
                        r_px <= vrss_pkg::sat24({{2{r_px[W-1]}}, r_px} + {{2{r_vx[W-1]}}, r_vx});
                        r_py <= vrss_pkg::sat24({{2{r_py[W-1]}}, r_py} + {{2{r_vy[W-1]}}, r_vy});
                        r_s1 <= 50'(avx) * 50'(avx);
                        r_s2 <= 50'(avy) * 50'(avy);
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (r_s1 + r_s2 > SQ_ONE / 50'd10000) begin
                        r_nx <= r_vx[W-1] ? -W'(decx) : W'(decx);
                        r_ny <= r_vy[W-1] ? -W'(decy) : W'(decy);
                    end else begin
                        r_nx <= '0; r_ny <= '0;
                    end
                    r_gx <= {{2{r_hx[W-1]}}, r_hx} - {{2{r_px[W-1]}}, r_px};
                    r_gy <= {{2{r_hy[W-1]}}, r_hy} - {{2{r_py[W-1]}}, r_py};
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_s1 <= 50'(mgx) * 50'(mgx) + 50'(mgy) * 50'(mgy);
                    r_state <= S_PULL;
                end
                S_PULL: begin
                    r_sel <= 1'b0;
                    r_state <= sq_start ? S_ROOT : S_WB;
                    if (!sq_start) begin
                        r_nx <= vrss_pkg::sat24(sumx); r_ny <= vrss_pkg::sat24(sumy);
                    end
                end
                S_ROOT: if (sq_done) begin
                    r_q <= sq_root; r_state <= S_DIVX;
                end
                S_DIVX: begin
                    if (dv_done && !r_sel) begin
                        r_quo_x <= dv_quo; r_sel <= 1'b1;
                    end else if (dv_done && r_sel) begin
                        r_nx <= vrss_pkg::sat24({{2{r_nx[W-1]}}, r_nx} + gxn);
                        r_ny <= vrss_pkg::sat24({{2{r_ny[W-1]}}, r_ny} + gyn);
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_cmd.req == vrss_pkg::REQ_TICK && !r_wr) begin
                        if (r_px[W-1]) r_nx <= ONE;
                        if (r_px > $signed({1'b0, i_bound_x, FRAC_BITS'(0)})) r_nx <= -ONE;
                        if (r_py[W-1]) r_ny <= ONE;
                        if (r_py > $signed({1'b0, i_bound_y, FRAC_BITS'(0)})) r_ny <= -ONE;
                        r_wr <= 1'b1;
                    end else begin
                        if (CW'(r_i) + 1'b1 >= r_count) r_state <= S_OUT;
                        else begin
                            r_i <= r_i + 1'b1; r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1; r_state <= S_IDLE;
                    o_out_x <= r_ox; o_out_y <= r_oy; o_status <= r_st;
                    o_loaded_count <= vrss_pkg::CNT_W'(r_count);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES)) else $error("count beyond table");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_we_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr |-> r_state != S_IDLE || r_cmd.req == vrss_pkg::REQ_LOAD)
        else $error("stray write");
endmodule
